/* hdl/asn1_comment_stripper_macros.svh */
// Assertion macros for the ASN.1 comment stripper.
// Depends on nothing; included by the top level, which supplies clk and rst.
`ifndef ASN1_COMMENT_STRIPPER_MACROS_SVH
`define ASN1_COMMENT_STRIPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ACS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/acs_pkg.sv */
// Package for the ASN.1 comment stripper: scan modes, characters, queue types.
// Depends on nothing.
package acs_pkg;

  localparam int unsigned NEST_MAX_DEF = 255;
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QAW          = 2;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [7:0] {
    MODE_NORMAL    = 8'b0000_0001,
    MODE_N_SLASH   = 8'b0000_0010,
    MODE_N_DASH    = 8'b0000_0100,
    MODE_DASH      = 8'b0000_1000,
    MODE_DASH_DASH = 8'b0001_0000,
    MODE_BLOCK     = 8'b0010_0000,
    MODE_B_SLASH   = 8'b0100_0000,
    MODE_B_STAR    = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } entry_t;

endpackage

/* hdl/asn1_comment_stripper.sv */
// Top level of the ASN.1 comment stripper: scanner state machine and output queue.
// Depends on acs_pkg and asn1_comment_stripper_macros.svh.

// Strips ASN.1 comments from a byte stream: "--" comments end at the next "--" or a
// newline, slash-star comments nest up to NEST_MAX deep (deeper openings are absorbed).
// Newlines inside comments are kept. A beat with tuser set flushes a pending '/' or '-'
// and resets the scanner state. Each input beat is decoded in the cycle it is taken and its
// 0 to 2 result bytes enter a 4-entry output queue; the block takes one input beat per cycle
// while the queue holds at most two bytes, so with m_tready high the sustained rate is one
// beat per cycle, limited by the one-beat-per-cycle output port when items yield two bytes.
`include "asn1_comment_stripper_macros.svh"

module asn1_comment_stripper #(
  parameter int unsigned NEST_MAX = acs_pkg::NEST_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tuser,   // func: 1 = end of stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast
);

  localparam int unsigned NW = (NEST_MAX < 2) ? 1 : $clog2(NEST_MAX + 1);
  localparam logic [NW-1:0] NEST_TOP = NW'(NEST_MAX);

  acs_pkg::mode_t mode, mode_next;
  logic [NW-1:0]  nest, nest_next;

  acs_pkg::entry_t             queue [acs_pkg::QDEPTH];
  logic [acs_pkg::QAW-1:0]     wr_ptr, rd_ptr;
  logic [acs_pkg::QAW:0]       count;

  logic       s_fire, m_fire;
  logic [1:0] n_out;
  logic [7:0] b0, b1;
  logic [7:0] c;

  assign c        = s_tdata;
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = m_tvalid && m_tready;
  assign s_tready = (count <= (acs_pkg::QAW + 1)'(acs_pkg::QDEPTH - 2));
  assign m_tvalid = (count != '0);
  assign m_tdata  = queue[rd_ptr].data;
  assign m_tlast  = queue[rd_ptr].last;

  always_comb begin
    mode_next = mode;
    nest_next = nest;
    n_out     = 2'd0;
    b0        = c;
    b1        = c;
    if (s_tuser) begin
      if (mode == acs_pkg::MODE_N_SLASH) begin
        n_out = 2'd1;
        b0    = acs_pkg::CH_SLASH;
      end else if (mode == acs_pkg::MODE_N_DASH) begin
        n_out = 2'd1;
        b0    = acs_pkg::CH_DASH;
      end
      mode_next = acs_pkg::MODE_NORMAL;
      nest_next = '0;
    end else begin
      unique case (mode)
        acs_pkg::MODE_NORMAL: begin
          if (c == acs_pkg::CH_SLASH) mode_next = acs_pkg::MODE_N_SLASH;
          else if (c == acs_pkg::CH_DASH) mode_next = acs_pkg::MODE_N_DASH;
          else n_out = 2'd1;
        end
        acs_pkg::MODE_N_SLASH: begin
          if (c == acs_pkg::CH_STAR) begin
            if (nest < NEST_TOP) nest_next = nest + NW'(1);
            mode_next = acs_pkg::MODE_BLOCK;
          end else begin
            n_out     = 2'd2;
            b0        = acs_pkg::CH_SLASH;
            mode_next = acs_pkg::MODE_NORMAL;
          end
        end
        acs_pkg::MODE_N_DASH: begin
          if (c == acs_pkg::CH_DASH) begin
            mode_next = acs_pkg::MODE_DASH;
          end else begin
            n_out     = 2'd2;
            b0        = acs_pkg::CH_DASH;
            mode_next = acs_pkg::MODE_NORMAL;
          end
        end
        acs_pkg::MODE_DASH: begin
          if (c == acs_pkg::CH_DASH) begin
            mode_next = acs_pkg::MODE_DASH_DASH;
          end else if (c == acs_pkg::CH_NL) begin
            n_out     = 2'd1;
            mode_next = acs_pkg::MODE_NORMAL;
          end
        end
        acs_pkg::MODE_DASH_DASH: begin
          if (c == acs_pkg::CH_DASH) begin
            mode_next = acs_pkg::MODE_NORMAL;
          end else if (c == acs_pkg::CH_NL) begin
            n_out     = 2'd1;
            mode_next = acs_pkg::MODE_NORMAL;
          end else begin
            mode_next = acs_pkg::MODE_DASH;
          end
        end
        acs_pkg::MODE_BLOCK: begin
          if (c == acs_pkg::CH_SLASH) mode_next = acs_pkg::MODE_B_SLASH;
          else if (c == acs_pkg::CH_STAR) mode_next = acs_pkg::MODE_B_STAR;
          else if (c == acs_pkg::CH_NL) n_out = 2'd1;
        end
        acs_pkg::MODE_B_SLASH: begin
          if (c == acs_pkg::CH_STAR) begin
            if (nest < NEST_TOP) nest_next = nest + NW'(1);
          end else if (c == acs_pkg::CH_NL) begin
            n_out = 2'd1;
          end
          mode_next = acs_pkg::MODE_BLOCK;
        end
        acs_pkg::MODE_B_STAR: begin
          if (c == acs_pkg::CH_SLASH) begin
            if (nest <= NW'(1)) begin
              nest_next = '0;
              mode_next = acs_pkg::MODE_NORMAL;
            end else begin
              nest_next = nest - NW'(1);
              mode_next = acs_pkg::MODE_BLOCK;
            end
          end else begin
            if (c == acs_pkg::CH_NL) n_out = 2'd1;
            mode_next = acs_pkg::MODE_BLOCK;
          end
        end
        default: begin
          mode_next = acs_pkg::MODE_NORMAL;
          nest_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= acs_pkg::MODE_NORMAL;
      nest   <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (s_fire) begin
        mode   <= mode_next;
        nest   <= nest_next;
        wr_ptr <= wr_ptr + acs_pkg::QAW'(n_out);
      end
      if (m_fire) rd_ptr <= rd_ptr + acs_pkg::QAW'(1);
      count <= count + (acs_pkg::QAW + 1)'(s_fire ? n_out : 2'd0)
                     - (acs_pkg::QAW + 1)'(m_fire);
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (s_fire && n_out != 2'd0) begin
      queue[wr_ptr] <= '{data: b0, last: (n_out == 2'd1)};
      if (n_out == 2'd2) queue[wr_ptr + acs_pkg::QAW'(1)] <= '{data: b1, last: 1'b1};
    end
  end

  `ACS_ASSERT_NOW(a_queue_bound, 1'b1, count <= (acs_pkg::QAW + 1)'(acs_pkg::QDEPTH), "queue overflow")
  `ACS_ASSERT_NOW(a_nest_mode, 1'b1, (nest != '0) == (mode == acs_pkg::MODE_BLOCK || mode == acs_pkg::MODE_B_SLASH || mode == acs_pkg::MODE_B_STAR), "nest depth out of step with mode")
  `ACS_ASSERT_NEXT(a_flush_reset, s_fire && s_tuser, mode == acs_pkg::MODE_NORMAL && nest == '0, "flush did not reset scanner")

endmodule

/* tb/asn1_comment_stripper_chk.sv */
// Scoreboard for the ASN.1 comment stripper: watches both stream ports, predicts the
// stripped text from the input beats and compares every output beat. Depends on acs_pkg.
`timescale 1ns / 1ps

module asn1_comment_stripper_chk #(
  parameter int unsigned NEST_MAX = acs_pkg::NEST_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  output int         fails,
  output int         pending,
  output int         results,
  output int         sat_hits,
  output int         deepest
);

  acs_pkg::mode_t  scan_st;
  logic [15:0]     depth;
  acs_pkg::entry_t exp_text[$];

  task automatic report(input string msg);
    $display("%0t ns  MISMATCH: %s", $time, msg);
    fails++;
  endtask

  function automatic void deepen();
    if (depth < NEST_MAX) begin
      depth++;
      if (depth > deepest) deepest = int'(depth);
    end else begin
      sat_hits++;
    end
  endfunction

  // Next scanner state and the 0..2 bytes that this beat releases.
  task automatic scan_byte(input logic eos, input logic [7:0] c);
    logic [7:0] outb[2];
    int n;
    n = 0;
    if (eos) begin
      if (scan_st == acs_pkg::MODE_N_SLASH) begin
        outb[n] = acs_pkg::CH_SLASH; n++;
      end else if (scan_st == acs_pkg::MODE_N_DASH) begin
        outb[n] = acs_pkg::CH_DASH; n++;
      end
      scan_st = acs_pkg::MODE_NORMAL;
      depth = '0;
    end else begin
      case (scan_st)
        acs_pkg::MODE_NORMAL: begin
          if (c == acs_pkg::CH_SLASH) scan_st = acs_pkg::MODE_N_SLASH;
          else if (c == acs_pkg::CH_DASH) scan_st = acs_pkg::MODE_N_DASH;
          else begin
            outb[n] = c; n++;
          end
        end
        acs_pkg::MODE_N_SLASH: begin
          if (c == acs_pkg::CH_STAR) begin
            deepen();
            scan_st = acs_pkg::MODE_BLOCK;
          end else begin
            outb[n] = acs_pkg::CH_SLASH; n++;
            outb[n] = c; n++;
            scan_st = acs_pkg::MODE_NORMAL;
          end
        end
        acs_pkg::MODE_N_DASH: begin
          if (c == acs_pkg::CH_DASH) scan_st = acs_pkg::MODE_DASH;
          else begin
            outb[n] = acs_pkg::CH_DASH; n++;
            outb[n] = c; n++;
            scan_st = acs_pkg::MODE_NORMAL;
          end
        end
        acs_pkg::MODE_DASH: begin
          if (c == acs_pkg::CH_DASH) scan_st = acs_pkg::MODE_DASH_DASH;
          else if (c == acs_pkg::CH_NL) begin
            outb[n] = acs_pkg::CH_NL; n++;
            scan_st = acs_pkg::MODE_NORMAL;
          end
        end
        acs_pkg::MODE_DASH_DASH: begin
          if (c == acs_pkg::CH_DASH) scan_st = acs_pkg::MODE_NORMAL;
          else if (c == acs_pkg::CH_NL) begin
            outb[n] = acs_pkg::CH_NL; n++;
            scan_st = acs_pkg::MODE_NORMAL;
          end else scan_st = acs_pkg::MODE_DASH;
        end
        acs_pkg::MODE_BLOCK: begin
          if (c == acs_pkg::CH_SLASH) scan_st = acs_pkg::MODE_B_SLASH;
          else if (c == acs_pkg::CH_STAR) scan_st = acs_pkg::MODE_B_STAR;
          else if (c == acs_pkg::CH_NL) begin
            outb[n] = acs_pkg::CH_NL; n++;
          end
        end
        acs_pkg::MODE_B_SLASH: begin
          if (c == acs_pkg::CH_STAR) deepen();
          else if (c == acs_pkg::CH_NL) begin
            outb[n] = acs_pkg::CH_NL; n++;
          end
          scan_st = acs_pkg::MODE_BLOCK;
        end
        acs_pkg::MODE_B_STAR: begin
          if (c == acs_pkg::CH_SLASH) begin
            if (depth <= 1) begin
              depth = '0;
              scan_st = acs_pkg::MODE_NORMAL;
            end else begin
              depth--;
              scan_st = acs_pkg::MODE_BLOCK;
            end
          end else begin
            if (c == acs_pkg::CH_NL) begin
              outb[n] = acs_pkg::CH_NL; n++;
            end
            scan_st = acs_pkg::MODE_BLOCK;
          end
        end
        default: scan_st = acs_pkg::MODE_NORMAL;
      endcase
    end
    for (int i = 0; i < n; i++) exp_text.push_back('{data: outb[i], last: (i == n - 1)});
  endtask

  initial begin
    fails    = 0;
    pending  = 0;
    results  = 0;
    sat_hits = 0;
    deepest  = 0;
    scan_st  = acs_pkg::MODE_NORMAL;
    depth    = '0;
  end

  always @(posedge clk) begin
    acs_pkg::entry_t want;
    if (rst) begin
      scan_st = acs_pkg::MODE_NORMAL;
      depth = '0;
      exp_text.delete();
    end else begin
      if (s_tvalid && s_tready) scan_byte(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        results++;
        if (exp_text.size() == 0) begin
          report($sformatf("unexpected output beat data=%02h last=%0b", m_tdata, m_tlast));
        end else begin
          want = exp_text.pop_front();
          if (m_tdata !== want.data)
            report($sformatf("beat %0d data got %02h want %02h", results, m_tdata, want.data));
          if (m_tlast !== want.last)
            report($sformatf("beat %0d last got %0b want %0b", results, m_tlast, want.last));
        end
      end
    end
    pending = exp_text.size();
  end

endmodule

/* tb/asn1_comment_stripper_tb.sv */
// Testbench top for the ASN.1 comment stripper: clock, reset, text stimulus, output
// backpressure, watchdog and verdict. Depends on acs_pkg and asn1_comment_stripper(_chk).
`timescale 1ns / 1ps

module asn1_comment_stripper_tb;

  localparam int TOTAL_BEATS    = 1200;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int fails, pending, results, sat_hits, deepest;
  int beats_sent, eos_sent, idle_cycles;
  bit in_quiet, out_quiet;

  asn1_comment_stripper DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  asn1_comment_stripper_chk CHK (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .fails    (fails),
    .pending  (pending),
    .results  (results),
    .sat_hits (sat_hits),
    .deepest  (deepest)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // One input beat; returns at the falling edge after it was taken.
  task automatic send_beat(input logic eos, input logic [7:0] b);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    if (eos) eos_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
  endtask

  // Mostly random bytes, with the characters the scanner cares about well represented.
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 7))
      0: return acs_pkg::CH_DASH;
      1: return acs_pkg::CH_SLASH;
      2: return acs_pkg::CH_STAR;
      3: return ($urandom_range(0, 1) != 0) ? acs_pkg::CH_NL : 8'h61;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_beat(1'b0, text_byte());
  endtask

  task automatic send_dash_comment();
    send_text("--");
    send_run($urandom_range(0, 6));
    if ($urandom_range(0, 1) != 0) send_text("--");
    else send_beat(1'b0, acs_pkg::CH_NL);
  endtask

  task automatic send_block_comment();
    int levels;
    levels = $urandom_range(1, 4);
    for (int i = 0; i < levels; i++) begin
      send_text("/*");
      send_run($urandom_range(0, 4));
    end
    for (int i = 0; i < levels; i++) begin
      send_text("*/");
      if (i < levels - 1) send_run($urandom_range(0, 3));
    end
  endtask

  // Opens past the nesting limit, then closes once per counted level: the comment
  // ends early and the trailing text must come through.
  task automatic send_deep_nest();
    for (int i = 0; i < acs_pkg::NEST_MAX_DEF + 2; i++) send_text("/*");
    for (int i = 0; i < acs_pkg::NEST_MAX_DEF; i++) send_text("*/");
    send_text("ok\n");
    send_beat(1'b1, 8'h00);
  endtask

  initial begin
    int pick;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = 1'b0;
    beats_sent = 0;
    eos_sent   = 0;
    in_quiet   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: byte extremes, lone slash and dash, newline after dash in a
    // dash comment, newlines after slash and star in a block, nesting,
    // flush of a pending slash and of an open comment
    send_beat(1'b0, acs_pkg::CH_SLASH);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b0, acs_pkg::CH_DASH);
    send_beat(1'b0, 8'h00);
    send_text("--c-\n");
    send_text("/*/\n*\n/**/*/");
    send_text("/");
    send_beat(1'b1, 8'hFF);
    send_text("/*a");
    send_beat(1'b1, 8'h00);

    send_deep_nest();

    while (beats_sent < TOTAL_BEATS) begin
      if ($urandom_range(0, 15) == 0) in_quiet = !in_quiet;
      pick = $urandom_range(0, 99);
      if (pick < 30) send_run($urandom_range(1, 6));
      else if (pick < 55) send_dash_comment();
      else if (pick < 85) send_block_comment();
      else if (pick < 93) begin
        for (int i = $urandom_range(1, 4); i > 0; i--) send_beat(1'b0, 8'($urandom_range(0, 255)));
      end else send_beat(1'b1, 8'($urandom_range(0, 255)));
    end
    send_beat(1'b1, 8'($urandom_range(0, 255)));
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d input beats (%0d end-of-stream flushes), checked %0d output beats.",
             beats_sent, eos_sent, results);
    $display("Block nesting reached depth %0d, with %0d openings absorbed at the limit.",
             deepest, sat_hits);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int stall;
    m_tready  = 1'b0;
    out_quiet = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
